FILE: rtl/sefd_pkg.sv
// Shared types and constants for the sync/escape frame decoder.
package sefd_pkg;

  localparam logic [7:0]  SYNC_BYTE       = 8'hE0;
  localparam logic [7:0]  ESC_BYTE        = 8'hD0;
  localparam logic [15:0] MAX_DECODED_RST = 16'd256;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NO_SYNC    = 3'd1,
    ST_STRAY_SYNC = 3'd2,
    ST_DOUBLE_ESC = 3'd3,
    ST_OVERFLOW   = 3'd4,
    ST_BAD_SUM    = 3'd5,
    ST_EMPTY      = 3'd6
  } status_t;

  typedef struct packed {
    logic       out_valid;
    logic [7:0] out_byte;
    logic       frame_end;
    status_t    status;
  } result_t;

endpackage

FILE: rtl/sefd_core.sv
// Per-byte frame state and decode logic; emits one result item per push.
module sefd_core
  import sefd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [7:0]  rx_byte,
  input  logic        last_byte,
  input  logic [15:0] max_decoded,
  output logic        push,
  output result_t     result
);

  logic        in_frame, in_frame_next;
  logic        escape_pending, escape_pending_next;
  status_t     error_code, error_code_next;
  logic [15:0] decoded_count, decoded_count_next;
  logic [7:0]  sum_before_last, sum_before_last_next;
  logic [7:0]  last_decoded, last_decoded_next;
  logic        dec_valid;
  logic [7:0]  dec_byte;
  status_t     end_status;

  always_comb begin
    in_frame_next        = in_frame;
    escape_pending_next  = escape_pending;
    error_code_next      = error_code;
    decoded_count_next   = decoded_count;
    sum_before_last_next = sum_before_last;
    last_decoded_next    = last_decoded;
    dec_valid            = 1'b0;
    dec_byte             = 8'd0;
    if (!in_frame) begin
      in_frame_next = 1'b1;
      if (rx_byte != SYNC_BYTE) begin
        error_code_next = ST_NO_SYNC;
      end
    end else if (error_code == ST_OK) begin
      if (rx_byte == SYNC_BYTE) begin
        error_code_next = ST_STRAY_SYNC;
      end else if (rx_byte == ESC_BYTE) begin
        if (escape_pending) begin
          error_code_next = ST_DOUBLE_ESC;
        end else begin
          escape_pending_next = 1'b1;
        end
      end else if (decoded_count >= max_decoded) begin
        error_code_next = ST_OVERFLOW;
      end else begin
        dec_byte            = escape_pending ? rx_byte + 8'd1 : rx_byte;
        dec_valid           = 1'b1;
        escape_pending_next = 1'b0;
        if (decoded_count != 16'd0) begin
          sum_before_last_next = sum_before_last + last_decoded;
        end
        last_decoded_next  = dec_byte;
        decoded_count_next = decoded_count + 16'd1;
      end
    end
  end

  always_comb begin
    if (error_code_next != ST_OK) begin
      end_status = error_code_next;
    end else if (decoded_count_next == 16'd0) begin
      end_status = ST_EMPTY;
    end else if (sum_before_last_next != last_decoded_next) begin
      end_status = ST_BAD_SUM;
    end else begin
      end_status = ST_OK;
    end
  end

  always_comb begin
    push             = accept && (dec_valid || last_byte);
    result.out_valid = dec_valid;
    result.out_byte  = dec_byte;
    result.frame_end = last_byte;
    result.status    = last_byte ? end_status : ST_OK;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame        <= 1'b0;
      escape_pending  <= 1'b0;
      error_code      <= ST_OK;
      decoded_count   <= 16'd0;
      sum_before_last <= 8'd0;
      last_decoded    <= 8'd0;
    end else if (accept) begin
      if (last_byte) begin
        in_frame        <= 1'b0;
        escape_pending  <= 1'b0;
        error_code      <= ST_OK;
        decoded_count   <= 16'd0;
        sum_before_last <= 8'd0;
        last_decoded    <= 8'd0;
      end else begin
        in_frame        <= in_frame_next;
        escape_pending  <= escape_pending_next;
        error_code      <= error_code_next;
        decoded_count   <= decoded_count_next;
        sum_before_last <= sum_before_last_next;
        last_decoded    <= last_decoded_next;
      end
    end
  end

endmodule

FILE: rtl/sefd_out_buf.sv
// Two-entry output register with skid stage for result items.
module sefd_out_buf
  import sefd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    main_vld;
  logic    skid_vld;
  result_t main_data;
  result_t skid_data;
  logic    pop;

  assign in_ready  = !skid_vld;
  assign out_valid = main_vld;
  assign out_data  = main_data;
  assign pop       = main_vld && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_vld <= 1'b0;
      skid_vld <= 1'b0;
    end else if (!main_vld || pop) begin
      if (skid_vld) begin
        main_vld <= 1'b1;
        skid_vld <= 1'b0;
      end else begin
        main_vld <= push;
      end
    end else if (push) begin
      skid_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_vld || pop) begin
      main_data <= skid_vld ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

FILE: rtl/sync_escape_frame_decoder.sv
// Top level of the sync/escape frame decoder.
// Result items are registered in the output buffer, via its skid entry on a stall.
// One byte per cycle while s_tready is high; decode state updates per accepted byte.
// A two-entry output buffer keeps input flowing while one result waits.
// Reset (synchronous, active high) clears frame state and sets max_decoded to 256.
module sync_escape_frame_decoder
  import sefd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic        s_tlast,   // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] out_byte, [10:8] status, [15:11] zero
  output logic        m_tuser,   // out_valid
  output logic        m_tlast,   // frame_end
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data   // max_decoded
);

  logic [15:0] max_decoded;
  logic        accept;
  logic        push;
  result_t     result;
  result_t     out_data;

  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_decoded <= MAX_DECODED_RST;
    end else if (cfg_valid && cfg_ready) begin
      max_decoded <= cfg_data;
    end
  end

  sefd_core u_core (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .rx_byte     (s_tdata),
    .last_byte   (s_tlast),
    .max_decoded (max_decoded),
    .push        (push),
    .result      (result)
  );

  sefd_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (result),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_data)
  );

  assign m_tdata = {5'd0, out_data.status, out_data.out_byte};
  assign m_tuser = out_data.out_valid;
  assign m_tlast = out_data.frame_end;

endmodule

FILE: sim/tb_top.sv
// Testbench for sync_escape_frame_decoder: queued byte frames, predicted results, checks.
`timescale 1ns / 1ps

module tb_top;
  import sefd_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } rx_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = 16'd0;

  sync_escape_frame_decoder dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  rx_item_t rx_queue[$];
  result_t  expected_decodes[$];
  int       mismatch_count = 0;
  int       queued_items = 0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  int       long_stall_reqs = 0;
  int       long_stall_seen = 0;
  int       stall_left = 0;

  // decoder state as predicted
  logic        in_frame = 1'b0;
  logic        esc_pend = 1'b0;
  status_t     frame_err = ST_OK;
  logic [15:0] dec_count = 16'd0;
  logic [7:0]  sum_prev = 8'd0;
  logic [7:0]  last_dec = 8'd0;
  logic [15:0] max_dec = MAX_DECODED_RST;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  function automatic void decode_rx_byte(rx_item_t it);
    result_t r;
    r.out_valid = 1'b0;
    r.out_byte  = 8'd0;
    r.frame_end = it.last;
    r.status    = ST_OK;
    if (!in_frame) begin
      in_frame = 1'b1;
      if (it.data != SYNC_BYTE) frame_err = ST_NO_SYNC;
    end else if (frame_err == ST_OK) begin
      if (it.data == SYNC_BYTE) begin
        frame_err = ST_STRAY_SYNC;
      end else if (it.data == ESC_BYTE) begin
        if (esc_pend) frame_err = ST_DOUBLE_ESC;
        else esc_pend = 1'b1;
      end else if (dec_count >= max_dec) begin
        frame_err = ST_OVERFLOW;
      end else begin
        r.out_byte = esc_pend ? it.data + 8'd1 : it.data;
        esc_pend = 1'b0;
        if (dec_count != 16'd0) sum_prev = sum_prev + last_dec;
        last_dec = r.out_byte;
        dec_count = dec_count + 16'd1;
        r.out_valid = 1'b1;
      end
    end
    if (it.last) begin
      if (frame_err != ST_OK) r.status = frame_err;
      else if (dec_count == 16'd0) r.status = ST_EMPTY;
      else if (sum_prev != last_dec) r.status = ST_BAD_SUM;
      else r.status = ST_OK;
      in_frame  = 1'b0;
      esc_pend  = 1'b0;
      frame_err = ST_OK;
      dec_count = 16'd0;
      sum_prev  = 8'd0;
      last_dec  = 8'd0;
    end
    if (r.out_valid || it.last) expected_decodes.push_back(r);
  endfunction

  // sender
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) begin
        decode_rx_byte(rx_queue[0]);
        rx_queue.pop_front();
      end
      if (rx_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_tvalid <= 1'b1;
        s_tdata  <= rx_queue[0].data;
        s_tlast  <= rx_queue[0].last;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (long_stall_seen != long_stall_reqs) begin
      long_stall_seen <= long_stall_reqs;
      stall_left <= 80;
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.out_valid = m_tuser;
      got.out_byte  = m_tdata[7:0];
      got.frame_end = m_tlast;
      got.status    = status_t'(m_tdata[10:8]);
      if (expected_decodes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: unexpected result valid=%0d byte=%02h end=%0d status=%0d",
                   $realtime, got.out_valid, got.out_byte, got.frame_end, got.status);
      end else begin
        want = expected_decodes.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: mismatch exp valid=%0d byte=%02h end=%0d status=%0d, got valid=%0d byte=%02h end=%0d status=%0d",
                     $realtime, want.out_valid, want.out_byte, want.frame_end, want.status,
                     got.out_valid, got.out_byte, got.frame_end, got.status);
        end
      end
    end
  end

  function automatic void push_item(logic [7:0] data, logic last);
    rx_item_t it;
    it.data = data;
    it.last = last;
    rx_queue.push_back(it);
    queued_items++;
  endfunction

  // send one decoded value, escaping it where needed or at random where possible
  function automatic void push_decoded(logic [7:0] v, logic last);
    logic [7:0] prev;
    prev = v - 8'd1;
    if (v == SYNC_BYTE || v == ESC_BYTE ||
        (prev != SYNC_BYTE && prev != ESC_BYTE && $urandom_range(4) == 0)) begin
      push_item(ESC_BYTE, 1'b0);
      push_item(prev, last);
    end else begin
      push_item(v, last);
    end
  endfunction

  function automatic void add_good_frame(int n, bit corrupt);
    logic [7:0] sum;
    logic [7:0] v;
    sum = 8'd0;
    push_item(SYNC_BYTE, 1'b0);
    for (int i = 0; i < n; i++) begin
      v = 8'($urandom);
      sum = sum + v;
      push_decoded(v, 1'b0);
    end
    if (corrupt) sum = sum ^ 8'($urandom_range(1, 255));
    push_decoded(sum, 1'b1);
  endfunction

  function automatic void add_noise_frame();
    int len;
    int pick;
    logic [7:0] b;
    len = $urandom_range(1, 8);
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(7);
      if (i == 0 && pick < 6) b = SYNC_BYTE;
      else if (pick < 2) b = SYNC_BYTE;
      else if (pick < 4) b = ESC_BYTE;
      else b = 8'($urandom);
      push_item(b, i == len - 1);
    end
  endfunction

  task automatic wait_drained();
    while (rx_queue.size() != 0 || s_tvalid) @(negedge clk);
    while (expected_decodes.size() != 0) @(negedge clk);
  endtask

  task automatic write_max_decoded(logic [15:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    max_dec = v;
    @(negedge clk);
  endtask

  logic [8:0]  directed_seq [27] = '{
    9'h1E0,
    9'h100,
    9'h0FF, 9'h112,
    9'h0E0, 9'h001, 9'h0E0, 9'h105,
    9'h0E0, 9'h0D0, 9'h0D0, 9'h101,
    9'h0E0, 9'h0D0, 9'h0FF, 9'h100,
    9'h0E0, 9'h055, 9'h156,
    9'h0E0, 9'h000, 9'h1D0,
    9'h0E0, 9'h1D0,
    9'h0E0, 9'h0FF, 9'h1FF
  };
  logic [15:0] cfg_plan [6];

  initial begin
    int phase_end;
    int mode;
    int pick;
    cfg_plan[0] = 16'd1;
    cfg_plan[1] = 16'd65535;
    cfg_plan[2] = 16'd3;
    cfg_plan[3] = 16'($urandom_range(4, 40));
    cfg_plan[4] = 16'd2;
    cfg_plan[5] = 16'($urandom_range(1, 65535));

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_seq[i]) push_item(directed_seq[i][7:0], directed_seq[i][8]);
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      repeat (4) @(negedge clk);
      write_max_decoded(cfg_plan[p]);
      mode = p % 4;
      send_idle_pct  = (mode == 1 || mode == 3) ? ((mode == 1) ? 83 : 24) : 0;
      recv_stall_pct = (mode == 2 || mode == 3) ? ((mode == 2) ? 83 : 24) : 0;
      if (p == 0) begin
        push_item(SYNC_BYTE, 1'b0);
        push_item(8'h01, 1'b0);
        push_item(8'h02, 1'b1);
      end
      phase_end = queued_items + 125;
      while (queued_items < phase_end - 60) begin
        pick = $urandom_range(99);
        if (pick < 75)
          add_good_frame(($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(6),
                         $urandom_range(7) == 0);
        else
          add_noise_frame();
      end
      if (mode == 0) long_stall_reqs++;
      wait_drained();
      while (queued_items < phase_end) begin
        pick = $urandom_range(99);
        if (pick < 75)
          add_good_frame($urandom_range(6), $urandom_range(7) == 0);
        else
          add_noise_frame();
      end
      wait_drained();
    end

    repeat (10) @(negedge clk);
    if (expected_decodes.size() != 0) begin
      mismatch_count += expected_decodes.size();
      $display("%0d expected results never arrived", expected_decodes.size());
    end
    if (mismatch_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
